FILE: rtl/rgbpi_pkg.sv
// ----------------------------------------------------------------------------
// rgbpi_pkg
// Shared types, constants and helpers for the RGB555 palette indexer.
// ----------------------------------------------------------------------------
package rgbpi_pkg;

  localparam int unsigned ColW = 15;
  localparam int unsigned IdxW = 8;
  localparam int unsigned CntW = 8;
  localparam logic [7:0]  MaxEntriesRst = 8'd255;

  // item travelling down the row of palette cells
  typedef struct packed {
    logic            busy;   // slot holds an item
    logic [ColW-1:0] col;    // packed 15-bit colour
    logic            last;   // final pixel of the image
    logic            done;   // resolved: matched or appended
    logic            newe;   // appended a new entry
    logic [IdxW-1:0] idx;    // palette index once resolved
    logic [CntW-1:0] cnt;    // entries held after this item
  } pix_t;

  // one result item as shown on the output ports
  typedef struct packed {
    logic [IdxW-1:0] pixel_index;
    logic [15:0]     color_word;
    logic            new_entry;
    logic            overflow;
    logic [CntW-1:0] entry_count;
    logic            last;
  } res_t;

  // cut each channel to its top 5 bits and pack blue, green, red
  function automatic logic [ColW-1:0] pack_col(input logic [7:0] red,
                                               input logic [7:0] green,
                                               input logic [7:0] blue);
    pack_col = {blue[7:3], green[7:3], red[7:3]};
  endfunction

  // turn an item leaving the row into its result; unresolved means overflow
  function automatic res_t to_result(input pix_t p);
    res_t r;
    r.pixel_index = p.done ? p.idx : '0;
    r.color_word  = {1'b1, p.col};
    r.new_entry   = p.newe;
    r.overflow    = ~p.done;
    r.entry_count = p.cnt;
    r.last        = p.last;
    to_result = r;
  endfunction

endpackage

FILE: rtl/rgb555_palette_indexer.sv
// ----------------------------------------------------------------------------
// rgb555_palette_indexer
// Builds a colour palette from an RGB pixel stream and indexes each pixel.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while no full skid stage freezes the row;
//   each pixel walks the palette cells one cell a cycle, then the output
//   register; a pixel always sees entries appended by the one ahead.
// Reset (rst_n low, synchronous): palette empty, max_entries = 255,
//   output and skid stages empty.
// The palette empties as the last pixel of an image walks the row.
module rgb555_palette_indexer #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_last_pixel,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_index,
  output logic [15:0] out_color_word,
  output logic        out_new_entry,
  output logic        out_overflow,
  output logic [7:0]  out_entry_count,
  output logic        out_last
);

  logic            [7:0] max_entries_r;
  logic                  adv;
  rgbpi_pkg::pix_t       chain [PALETTE_DEPTH+1];
  rgbpi_pkg::res_t       res;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= rgbpi_pkg::MaxEntriesRst;
    end else if (cfg_valid && cfg_ready) begin
      max_entries_r <= cfg_data;
    end
  end

  // build the incoming item
  assign in_stall = ~adv;

  always_comb begin
    chain[0]      = '0;
    chain[0].busy = in_valid & ~in_stall;
    chain[0].col  = rgbpi_pkg::pack_col(in_red, in_green, in_blue);
    chain[0].last = in_last_pixel;
  end

  // row of palette cells
  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    rgbpi_cell #(
      .CELL_INDEX (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .limit     (max_entries_r),
      .pix_in    (chain[k]),
      .pix_out_r (chain[k+1])
    );
  end

  // output register and skid stage
  rgbpi_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_in    (chain[PALETTE_DEPTH]),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_pixel_index = res.pixel_index;
  assign out_color_word  = res.color_word;
  assign out_new_entry   = res.new_entry;
  assign out_overflow    = res.overflow;
  assign out_entry_count = res.entry_count;
  assign out_last        = res.last;

endmodule

FILE: rtl/rgbpi_cell.sv
// ----------------------------------------------------------------------------
// rgbpi_cell
// One palette entry: compares the passing item, claims the entry when the
// colour is new and the limit allows, and clears after the last pixel.
// ----------------------------------------------------------------------------
module rgbpi_cell #(
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [7:0]            limit,
  input  rgbpi_pkg::pix_t       pix_in,
  output rgbpi_pkg::pix_t       pix_out_r
);

  localparam logic [rgbpi_pkg::IdxW-1:0] CellIdx = rgbpi_pkg::IdxW'(CELL_INDEX);
  localparam logic [rgbpi_pkg::CntW-1:0] CellCnt = rgbpi_pkg::CntW'(CELL_INDEX + 1);

  logic                       used_r, used_nxt;
  logic [rgbpi_pkg::ColW-1:0] entry_r, entry_nxt;
  rgbpi_pkg::pix_t            pix_nxt;
  logic                       match;
  logic                       claim;

  // compare against the held colour, or take the entry while under the limit
  always_comb begin
    match     = used_r && (entry_r == pix_in.col);
    claim     = !used_r && (CellIdx < limit);
    pix_nxt   = pix_in;
    used_nxt  = used_r;
    entry_nxt = entry_r;
    if (pix_in.busy) begin
      if (!pix_in.done && match) begin
        pix_nxt.done = 1'b1;
        pix_nxt.idx  = CellIdx;
      end else if (!pix_in.done && claim) begin
        pix_nxt.done = 1'b1;
        pix_nxt.newe = 1'b1;
        pix_nxt.idx  = CellIdx;
        entry_nxt    = pix_in.col;
        used_nxt     = 1'b1;
      end
      // entries fill from zero upward, so a held entry here sets the count
      if (used_nxt) begin
        pix_nxt.cnt = CellCnt;
      end
      // drop the entry once the last pixel of the image has gone past
      if (pix_in.last) begin
        used_nxt = 1'b0;
      end
    end
  end

  // hold the entry and advance the item with the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= 1'b0;
      pix_out_r <= '0;
    end else if (adv) begin
      used_r    <= used_nxt;
      entry_r   <= entry_nxt;
      pix_out_r <= pix_nxt;
    end
  end

endmodule

FILE: rtl/rgbpi_out_buf.sv
// ----------------------------------------------------------------------------
// rgbpi_out_buf
// Output register with a skid stage; freezes the cell row only when both
// hold an item.
// ----------------------------------------------------------------------------
module rgbpi_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  rgbpi_pkg::pix_t  pix_in,
  input  logic             out_stall,
  output logic             adv,
  output logic             out_valid,
  output rgbpi_pkg::res_t  res
);

  logic            out_valid_r, out_valid_nxt;
  logic            skid_full_r, skid_full_nxt;
  rgbpi_pkg::res_t out_data_r;
  rgbpi_pkg::res_t skid_data_r;
  logic            take;
  logic            arrive;
  logic            load_out;
  logic            load_skid;
  logic            pop_skid;

  assign adv    = ~skid_full_r;
  assign take   = out_valid_r & ~out_stall;
  assign arrive = adv & pix_in.busy;

  // steer arriving items and refill from the skid stage
  always_comb begin
    pop_skid      = skid_full_r & take;
    load_out      = arrive & (~out_valid_r | take);
    load_skid     = arrive & out_valid_r & ~take;
    out_valid_nxt = out_valid_r;
    skid_full_nxt = skid_full_r;
    if (pop_skid) begin
      skid_full_nxt = 1'b0;
    end else if (load_skid) begin
      skid_full_nxt = 1'b1;
    end
    if (load_out || pop_skid) begin
      out_valid_nxt = 1'b1;
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  // hold payload until taken
  always_ff @(posedge clk) begin
    if (pop_skid) begin
      out_data_r <= skid_data_r;
    end else if (load_out) begin
      out_data_r <= rgbpi_pkg::to_result(pix_in);
    end
    if (load_skid) begin
      skid_data_r <= rgbpi_pkg::to_result(pix_in);
    end
  end

  assign out_valid = out_valid_r;
  assign res       = out_data_r;

endmodule

FILE: rtl/rgbpi_checker.sv
// ----------------------------------------------------------------------------
// rgbpi_checker
// Port-level checks on the result stream of the palette indexer.
// ----------------------------------------------------------------------------
module rgbpi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_pixel_index,
  input logic [15:0] out_color_word,
  input logic        out_new_entry,
  input logic        out_overflow,
  input logic [7:0]  out_entry_count
);

  // a stalled item stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_index)
      && $stable(out_color_word) && $stable(out_entry_count))
    else $error("result changed while stalled");

  // overflow gives index 0 and appends nothing
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_pixel_index == 8'd0 && !out_new_entry)
    else $error("overflow item carries an index or a new entry");

  // a new entry is the topmost one held
  a_new_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_entry |-> out_pixel_index + 8'd1 == out_entry_count)
    else $error("new entry index does not match entry count");

  // a resolved index lies inside the palette
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |-> out_pixel_index < out_entry_count)
    else $error("index beyond entries held");

  // alpha bit always set
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_color_word[15])
    else $error("alpha bit clear in colour word");

endmodule

bind rgb555_palette_indexer rgbpi_checker u_rgbpi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel_index (out_pixel_index),
  .out_color_word  (out_color_word),
  .out_new_entry   (out_new_entry),
  .out_overflow    (out_overflow),
  .out_entry_count (out_entry_count)
);

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: RGB555 palette indexer testbench
// Streams RGB pixels through the indexer under several palette limits,
// predicts index, colour word, new-entry, overflow and count for every
// pixel and checks each result in order. Both channels idle and stall at
// random; one long receiver hold-off backs the block up onto its input.
// ----------------------------------------------------------------------------
module tb;

  localparam int PIPE_LATENCY   = 256;
  localparam int HOLD_CYCLES    = 700;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TARGET_PIXELS  = 1700;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic        in_last_pixel = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_pixel_index;
  logic [15:0] out_color_word;
  logic        out_new_entry;
  logic        out_overflow;
  logic [7:0]  out_entry_count;
  logic        out_last;

  // palette mirror and its limit
  logic [14:0] pal_colors [256];
  int          pal_count = 0;
  logic [7:0]  max_entries_q = rgbpi_pkg::MaxEntriesRst;

  pixel_t          pending_pixels[$];
  rgbpi_pkg::res_t predicted_results[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  pixels_queued = 0;
  int  new_seen = 0;
  int  overflow_seen = 0;
  int  images_closed = 0;
  int  limits_used = 0;
  int  send_gap = 0;
  int  recv_wait = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;
  bit  hold_done = 1'b0;
  logic holding = 1'b0;

  rgb555_palette_indexer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_last_pixel   (in_last_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_index (out_pixel_index),
    .out_color_word  (out_color_word),
    .out_new_entry   (out_new_entry),
    .out_overflow    (out_overflow),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Look the pixel up in the palette, append it if there is room
  function automatic rgbpi_pkg::res_t index_pixel(input logic [7:0] red,
                                                  input logic [7:0] green,
                                                  input logic [7:0] blue,
                                                  input logic last_pixel);
    rgbpi_pkg::res_t res;
    logic [14:0]     col;
    bit              hit;
    col = {blue[7:3], green[7:3], red[7:3]};
    hit = 1'b0;
    res.pixel_index = '0;
    res.new_entry   = 1'b0;
    res.overflow    = 1'b0;
    for (int k = 0; k < pal_count; k++) begin
      if (!hit && pal_colors[k] == col) begin
        res.pixel_index = 8'(k);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (pal_count < int'(max_entries_q)) begin
        res.pixel_index = 8'(pal_count);
        pal_colors[pal_count] = col;
        pal_count++;
        res.new_entry = 1'b1;
      end else begin
        res.overflow = 1'b1;
      end
    end
    res.color_word  = {1'b1, col};
    res.entry_count = 8'(pal_count);
    res.last        = last_pixel;
    // the palette empties once the last pixel of an image is answered
    if (last_pixel) pal_count = 0;
    return res;
  endfunction

  // Wait count for the next item; flip into and out of gap-free stretches
  function automatic int draw_wait(ref bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, 11));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("ERROR t=%0t result %0d: %s got %0d want %0d", $time, results_seen, what,
               got, want);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.red        = 8'($urandom);
    px.green      = 8'($urandom);
    px.blue       = 8'($urandom);
    px.last_pixel = 1'b0;
    return px;
  endfunction

  task automatic queue_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic last_pixel);
    pending_pixels.push_back('{red, green, blue, last_pixel});
    pixels_queued++;
  endtask

  // One image: colours mostly drawn from a small pool, low bits varied,
  // with the odd stray end-of-image mark
  task automatic queue_image(input int len, input int pool_sz, input bit terminate);
    pixel_t pool[$];
    pixel_t px;
    for (int i = 0; i < pool_sz; i++) pool.push_back(random_pixel());
    for (int i = 0; i < len; i++) begin
      if (pool_sz > 0 && $urandom_range(0, 99) < 85) begin
        px = pool[$urandom_range(0, pool_sz - 1)];
        px.red[2:0]   = 3'($urandom);
        px.green[2:0] = 3'($urandom);
        px.blue[2:0]  = 3'($urandom);
      end else begin
        px = random_pixel();
      end
      px.last_pixel = (terminate && i == len - 1) || ($urandom_range(0, 49) == 0);
      pending_pixels.push_back(px);
      pixels_queued++;
    end
  endtask

  task automatic queue_images(input int lim, input int n_items);
    int target;
    target = pixels_queued + n_items;
    while (pixels_queued < target)
      queue_image($urandom_range(1, 60), $urandom_range(1, (lim < 40) ? lim + 6 : 40),
                  $urandom_range(0, 9) != 0);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || predicted_results.size() != 0);
  endtask

  // Drain the block, then write the palette limit
  task automatic set_limit(input logic [7:0] lim);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    do @(posedge clk);
    while (!cfg_ready);
    max_entries_q = lim;
    limits_used++;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    int lim;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limit: extremes, truncation hits, then close the image
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd7, 8'd7, 8'd7, 1'b0);
    queue_pixel(8'd248, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd0, 8'd248, 8'd0, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd248, 1'b0);
    queue_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
    queue_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b1);

    // one entry only: append, hit, then overflow, overflow on the last pixel
    set_limit(8'd1);
    queue_pixel(8'd10, 8'd20, 8'd30, 1'b0);
    queue_pixel(8'd15, 8'd23, 8'd31, 1'b0);
    queue_pixel(8'd200, 8'd100, 8'd50, 1'b0);
    queue_pixel(8'd200, 8'd100, 8'd50, 1'b1);

    // limit of zero: every colour overflows
    set_limit(8'd0);
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b1);

    set_limit(8'd2);
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd8, 8'd8, 8'd8, 1'b0);
    queue_pixel(8'd1, 8'd2, 8'd3, 1'b0);
    queue_pixel(8'd16, 8'd16, 8'd16, 1'b0);
    queue_pixel(8'd8, 8'd8, 8'd8, 1'b1);

    // full limit: 300 random-colour pixels, more than the palette holds,
    // then enough backlog for the receiver hold-off to fill the block
    set_limit(8'd255);
    queue_image(300, 0, 1'b1);
    queue_images(255, 250);

    // random limits until the pixel budget is spent
    while (pixels_queued < TARGET_PIXELS) begin
      case ($urandom_range(0, 5))
        0:       lim = 1;
        1:       lim = 255;
        2:       lim = $urandom_range(1, 255);
        default: lim = $urandom_range(2, 16);
      endcase
      set_limit(8'(lim));
      queue_images(lim, 150);
    end

    wait_idle();
    repeat (PIPE_LATENCY + 50) @(posedge clk);
    if (predicted_results.size() != 0)
      report_mismatch("results never delivered", 0, predicted_results.size());
    $display("Covered %0d pixels under %0d limit writes, %0d images closed.",
             pixels_queued, limits_used, images_closed);
    $display("Saw %0d new entries and %0d overflows; long receiver hold-off %s.",
             new_seen, overflow_seen, hold_done ? "applied" : "not reached");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Driver: predict each accepted item, then offer the next after its gap
  always @(posedge clk) begin
    pixel_t px;
    logic   offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = in_valid;
      if (in_valid && !in_stall) begin
        predicted_results.push_back(index_pixel(in_red, in_green, in_blue, in_last_pixel));
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0 && !holding) begin
          send_gap--;
        end else if (pending_pixels.size() > 0) begin
          px = pending_pixels.pop_front();
          in_red        <= px.red;
          in_green      <= px.green;
          in_blue       <= px.blue;
          in_last_pixel <= px.last_pixel;
          offer = 1'b1;
          send_gap = draw_wait(send_burst);
        end
      end
      in_valid <= offer;
    end
  end

  // Monitor: check each accepted item, then draw the stall before the next
  always @(posedge clk) begin
    rgbpi_pkg::res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      holding   <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result, index", out_pixel_index, -1);
        end else begin
          want = predicted_results.pop_front();
          if (out_pixel_index !== want.pixel_index)
            report_mismatch("pixel_index", out_pixel_index, want.pixel_index);
          if (out_color_word !== want.color_word)
            report_mismatch("color_word", out_color_word, want.color_word);
          if (out_new_entry !== want.new_entry)
            report_mismatch("new_entry", out_new_entry, want.new_entry);
          if (out_overflow !== want.overflow)
            report_mismatch("overflow", out_overflow, want.overflow);
          if (out_entry_count !== want.entry_count)
            report_mismatch("entry_count", out_entry_count, want.entry_count);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
        end
        results_seen++;
        if (out_new_entry === 1'b1) new_seen++;
        if (out_overflow === 1'b1) overflow_seen++;
        if (out_last === 1'b1) images_closed++;
        recv_wait = draw_wait(recv_burst);
        // hold off once while a deep backlog is still waiting to be sent
        if (!hold_done && pending_pixels.size() > 200) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= (hold_left > 0) || (recv_wait > 0);
      holding   <= (hold_left > 0);
    end
  end

  // Watchdog: end the run when no channel has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, predicted_results.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
